// ===== rtl/core/pdfsd_pkg.sv =====
package pdfsd_pkg;

  // Configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [0:0]  REG_MAX_LEN = 1'b0;
  localparam logic [7:0]  MAX_LEN_RST = 8'd47;

  // Upper bound on bytes per string, independent of the register
  localparam int unsigned LEN_LIMIT_DEF = 255;

  // Queue of results between the parser and the output port
  localparam int unsigned RESQ_DEPTH = 4;

  // Delimiters and escape characters
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;

  localparam logic [7:0] ESC_LF = 8'h0A;
  localparam logic [7:0] ESC_CR = 8'h0D;
  localparam logic [7:0] ESC_HT = 8'h09;
  localparam logic [7:0] ESC_BS = 8'h08;
  localparam logic [7:0] ESC_FF = 8'h0C;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       trunc;
  } res_t;

  // Results of one input byte: count (0..2) and the results in order
  typedef struct packed {
    logic [1:0]     num;
    res_t [1:0]     res;
  } step_t;

endpackage

// ===== rtl/core/pdf_string_decoder_core.sv =====
// A decoded byte enters the result queue when its input byte is taken and is offered on the out_ side in order.
// Throughput: one input byte per cycle; a byte that yields two results takes two output
//   handshakes, and in_ready drops while the four-entry result queue holds more than two entries.
// Reset (synchronous, rst_n low): parser returns to idle with all per-string state cleared,
//   the result queue empties and max_len returns to 47.
module pdf_string_decoder_core #(
  parameter int unsigned LEN_LIMIT = pdfsd_pkg::LEN_LIMIT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input request: one raw content-stream byte
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_byte,
  input  logic                            in_stream_end,
  // Result request: one decoded byte or an end-of-string marker
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_byte,
  output logic                            out_byte_valid,
  output logic                            out_last,
  output logic                            out_truncated,
  // Register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pdfsd_pkg::PADDR_W-1:0]   paddr,
  input  logic [pdfsd_pkg::PDATA_W-1:0]   pwdata,
  output logic [pdfsd_pkg::PDATA_W-1:0]   prdata,
  output logic                            pready
);
  import pdfsd_pkg::*;

  logic       in_fire;
  logic       out_fire;
  logic [7:0] max_len_r;
  logic       reg_hit;
  step_t      step;
  res_t       head;

  // The register is selected when paddr[2] is 0; addresses with paddr[2] set read zero and ignore writes
  assign reg_hit = paddr[PADDR_W-1] == REG_MAX_LEN;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? PDATA_W'(max_len_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RST;
    end else if (psel && penable && pwrite && reg_hit) begin
      max_len_r <= pwdata[7:0];
    end
  end

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Byte decode and string state; produces zero to two results per accepted byte
  pdfsd_parser #(
    .LEN_LIMIT (LEN_LIMIT)
  ) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (in_fire),
    .in_byte       (in_byte),
    .in_stream_end (in_stream_end),
    .max_len       (max_len_r),
    .step          (step)
  );

  // Result queue decouples the two sides; advance on every output handshake
  pdfsd_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .step      (step),
    .pop       (out_fire),
    .has_room  (in_ready),
    .not_empty (out_valid),
    .head      (head)
  );

  assign out_byte       = head.data;
  assign out_byte_valid = head.valid;
  assign out_last       = head.last;
  assign out_truncated  = head.trunc;

  // A result without a decoded byte only ever marks the end of a string
  a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_last)
    else $error("non-byte result without last");

  // The truncation flag is only reported on the final result of a string
  a_trunc_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_truncated |-> out_last)
    else $error("truncated set on a non-final result");

  // With nothing accepted and nothing taken, the output side holds still
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && !in_fire |=> out_valid && $stable(head))
    else $error("stalled result changed");

  // Queue must never be refused space: a full step always fits when accepted
  a_room_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && step.num == 2'd2 |=> out_valid)
    else $error("accepted results lost");

endmodule

// ===== rtl/core/pdfsd_parser.sv =====
module pdfsd_parser #(
  parameter int unsigned LEN_LIMIT = pdfsd_pkg::LEN_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        in_byte,
  input  logic              in_stream_end,
  input  logic [7:0]        max_len,
  output pdfsd_pkg::step_t  step
);
  import pdfsd_pkg::*;

  localparam int unsigned CW = $clog2(LEN_LIMIT + 1);

  typedef enum logic [1:0] {M_IDLE, M_LIT, M_HEX} mode_t;

  mode_t         mode_r, mode_nxt;
  logic [7:0]    depth_r, depth_nxt;
  logic          esc_r, esc_nxt;
  logic [8:0]    oval_r, oval_nxt;
  logic [1:0]    odig_r, odig_nxt;
  logic [3:0]    hnib_r, hnib_nxt;
  logic          nheld_r, nheld_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          drop_r, drop_nxt;

  logic [2:0]       req;
  logic [2:0][7:0]  req_byte;
  logic             closing;
  logic             oct_dig;
  logic [8:0]       oval_sh;
  logic [4:0]       hex;
  logic [7:0]       lim;
  logic [CW-1:0]    cnt_v;
  logic             drop_v;
  logic [1:0]       num_v;
  res_t [1:0]       res_v;

  function automatic logic [4:0] hex_nib(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c inside {["0":"9"]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {["a":"f"], ["A":"F"]}) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

  assign oct_dig = in_byte inside {[CH_0:CH_7]};
  assign oval_sh = {oval_r[5:0], in_byte[2:0]};
  assign hex     = hex_nib(in_byte);
  assign lim     = (max_len < 8'(LEN_LIMIT)) ? max_len : 8'(LEN_LIMIT);

  // Parse one byte: collect up to three ordered emit requests
  always_comb begin
    mode_nxt  = mode_r;
    depth_nxt = depth_r;
    esc_nxt   = esc_r;
    oval_nxt  = oval_r;
    odig_nxt  = odig_r;
    hnib_nxt  = hnib_r;
    nheld_nxt = nheld_r;
    req       = '0;
    req_byte  = '0;
    closing   = 1'b0;

    case (mode_r)
      M_LIT: begin
        if (odig_r != 2'd0 && oct_dig) begin
          if (odig_r == 2'd2) begin
            req[0]      = 1'b1;
            req_byte[0] = oval_sh[7:0];
            oval_nxt    = '0;
            odig_nxt    = '0;
          end else begin
            oval_nxt = oval_sh;
            odig_nxt = odig_r + 2'd1;
          end
        end else begin
          if (odig_r != 2'd0) begin
            req[0]      = 1'b1;
            req_byte[0] = oval_r[7:0];
            oval_nxt    = '0;
            odig_nxt    = '0;
          end
          if (esc_r) begin
            esc_nxt     = 1'b0;
            req[1]      = 1'b1;
            req_byte[1] = in_byte;
            case (in_byte)
              CH_N: req_byte[1] = ESC_LF;
              CH_R: req_byte[1] = ESC_CR;
              CH_T: req_byte[1] = ESC_HT;
              CH_B: req_byte[1] = ESC_BS;
              CH_F: req_byte[1] = ESC_FF;
              default: begin
                if (oct_dig) begin
                  req[1]   = 1'b0;
                  oval_nxt = {6'd0, in_byte[2:0]};
                  odig_nxt = 2'd1;
                end
              end
            endcase
          end else if (in_byte == CH_BSLASH) begin
            esc_nxt = 1'b1;
          end else if (in_byte == CH_LPAREN) begin
            if (depth_r != 8'hFF) depth_nxt = depth_r + 8'd1;
            req[1]      = 1'b1;
            req_byte[1] = in_byte;
          end else if (in_byte == CH_RPAREN) begin
            if (depth_r <= 8'd1) begin
              closing = 1'b1;
            end else begin
              depth_nxt   = depth_r - 8'd1;
              req[1]      = 1'b1;
              req_byte[1] = in_byte;
            end
          end else begin
            req[1]      = 1'b1;
            req_byte[1] = in_byte;
          end
        end
      end
      M_HEX: begin
        if (in_byte == CH_GT) begin
          closing = 1'b1;
        end else if (hex[4]) begin
          if (!nheld_r) begin
            hnib_nxt  = hex[3:0];
            nheld_nxt = 1'b1;
          end else begin
            req[1]      = 1'b1;
            req_byte[1] = {hnib_r, hex[3:0]};
            hnib_nxt    = '0;
            nheld_nxt   = 1'b0;
          end
        end
      end
      default: begin
        if (in_byte == CH_LPAREN) begin
          mode_nxt  = M_LIT;
          depth_nxt = 8'd1;
        end else if (in_byte == CH_LT) begin
          mode_nxt = M_HEX;
        end
      end
    endcase

    // End of stream closes an open string; flush a pending octal escape
    if (in_stream_end && mode_nxt != M_IDLE && !closing) begin
      closing = 1'b1;
      if (odig_nxt != 2'd0) begin
        req[2]      = 1'b1;
        req_byte[2] = oval_nxt[7:0];
      end
    end
  end

  // Apply the length limit to the emit requests in order
  always_comb begin
    cnt_v  = cnt_r;
    drop_v = drop_r;
    num_v  = '0;
    res_v  = '0;
    for (int i = 0; i < 3; i++) begin
      if (req[i]) begin
        if (8'(cnt_v) < lim && num_v != 2'd2) begin
          res_v[num_v[0]] = '{data: req_byte[i], valid: 1'b1, last: 1'b0, trunc: 1'b0};
          num_v           = num_v + 2'd1;
          cnt_v           = CW'(cnt_v + 1'b1);
        end else begin
          drop_v = 1'b1;
        end
      end
    end
    if (closing) begin
      if (num_v == 2'd0) begin
        num_v = 2'd1;
      end
      if (num_v == 2'd2) begin
        res_v[1].last  = 1'b1;
        res_v[1].trunc = drop_v;
      end else begin
        res_v[0].last  = 1'b1;
        res_v[0].trunc = drop_v;
      end
    end
    cnt_nxt  = cnt_v;
    drop_nxt = drop_v;
  end

  assign step.num = num_v;
  assign step.res = res_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      depth_r <= '0;
      esc_r   <= 1'b0;
      oval_r  <= '0;
      odig_r  <= '0;
      hnib_r  <= '0;
      nheld_r <= 1'b0;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
    end else if (fire) begin
      if (closing) begin
        mode_r  <= M_IDLE;
        depth_r <= '0;
        esc_r   <= 1'b0;
        oval_r  <= '0;
        odig_r  <= '0;
        hnib_r  <= '0;
        nheld_r <= 1'b0;
        cnt_r   <= '0;
        drop_r  <= 1'b0;
      end else begin
        mode_r  <= mode_nxt;
        depth_r <= depth_nxt;
        esc_r   <= esc_nxt;
        oval_r  <= oval_nxt;
        odig_r  <= odig_nxt;
        hnib_r  <= hnib_nxt;
        nheld_r <= nheld_nxt;
        cnt_r   <= cnt_nxt;
        drop_r  <= drop_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/pdfsd_resq.sv =====
module pdfsd_resq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pdfsd_pkg::step_t  step,
  input  logic              pop,
  output logic              has_room,
  output logic              not_empty,
  output pdfsd_pkg::res_t   head
);
  import pdfsd_pkg::*;

  localparam int unsigned PW = $clog2(RESQ_DEPTH);
  localparam int unsigned NW = $clog2(RESQ_DEPTH + 1);

  res_t [RESQ_DEPTH-1:0] mem_r;
  logic [PW-1:0]         wp_r, rp_r;
  logic [NW-1:0]         cnt_r, cnt_nxt;
  logic [1:0]            num_in;
  logic                  do_pop;

  assign num_in    = push ? step.num : 2'd0;
  assign do_pop    = pop && not_empty;
  assign not_empty = cnt_r != '0;
  // Room for a full step of two results
  assign has_room  = cnt_r <= NW'(RESQ_DEPTH - 2);
  assign head      = mem_r[rp_r];
  assign cnt_nxt   = NW'(cnt_r + NW'(num_in) - NW'(do_pop));

  always_ff @(posedge clk) begin
    if (num_in != 2'd0) mem_r[wp_r] <= step.res[0];
    if (num_in == 2'd2) mem_r[PW'(wp_r + 1'b1)] <= step.res[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= PW'(wp_r + PW'(num_in));
      rp_r  <= PW'(rp_r + PW'(do_pop));
      cnt_r <= cnt_nxt;
    end
  end

endmodule
